>>> rtl/robin_hood_hash_table_assert.svh
// Assertion macros for the Robin Hood hash table checker.
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
// Clocked assertion, off while reset is applied.
`define RHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define RHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RHT_ASSERT(lbl, (ante) |=> (cons), msg)
`endif

>>> rtl/rht_pkg.sv
// Types and constants shared by the Robin Hood hash table files.
package rht_pkg;

  // TABLE_SIZE must be a power of two: home slot is the low hash bits.
  localparam int unsigned TABLE_SIZE  = 64;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W       = $clog2(TABLE_SIZE + 1);
  localparam int unsigned PCT_W       = $clog2(100 * (TABLE_SIZE + 1) + 1);
  localparam logic [6:0]  LIMIT_RESET = 7'd80;
  localparam logic [6:0]  LIMIT_MAX   = 7'd100;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key_hash;
    logic [3:0]  key_length;
    logic [63:0] key_bytes;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        status;
  } out_word_t;

  typedef struct packed {
    logic [31:0]            hash;
    logic [3:0]             len;
    logic [63:0]            key;
    logic [VALUE_WIDTH-1:0] value;
  } slot_t;

  // Byte mask over the compared key bytes.
  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < KEY_BYTES && 4'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/robin_hood_hash_table.sv
// Robin Hood hash table with linear probing, one probe step per slot read and compare.
//
// Input channel: in_valid_i / in_stall_o carry one request word (get or set
// with key hash, length, bytes and value). A word is taken when valid is high
// and stall is low; stall stays high from the cycle after an accept until
// that request's result has left the sequencer.
// Output channel: out_valid_o / out_stall_i carry one result word per
// request from an output register; the next request may be taken while a
// result still sits there.
// Sequence: a refused set goes from the idle state straight to the done
// state. Otherwise each probed slot takes a read state (one registered read
// of the slot memory) and a compare state (on the shared compare unit),
// then the done state hands off. A set that displaces residents restarts
// the probe from each carried entry's home slot; one request at a time.
// Reset: all slots invalid, entry count zero, load limit 80 percent. No
// clearing pass: valid bits are flip-flops.
// Stall: a held result keeps its word; a finished request waits in the
// done state until the output register frees up.
// Config: cfg_we_i writes the load limit (percent); the user writes it only while the block is idle (not enforced).
module robin_hood_hash_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rht_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rht_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  rht_pkg::slot_t mem [rht_pkg::TABLE_SIZE];
  rht_pkg::slot_t rd_q;       // registered read data
  rht_pkg::slot_t c_q, c_d;   // carried entry
  rht_pkg::slot_t wdata;
  logic           we, re;

  logic [rht_pkg::TABLE_SIZE-1:0] valid_q, valid_d;
  logic [rht_pkg::IDX_W-1:0]      pos_q, pos_d, d_q, d_d;
  logic [rht_pkg::CNT_W-1:0]      count_q, count_d, iter_q, iter_d;
  logic                           req_q, req_d, first_q, first_d;
  logic [6:0]                     lim_q;
  rht_pkg::out_word_t             res_q, res_d, out_q;
  logic                           out_vld_q;
  logic                           out_load;

  // load check
  logic [6:0]                 lim_eff;
  logic [rht_pkg::PCT_W-1:0]  pct;
  logic                       refuse;

  // compare unit
  logic                      slot_v, match, stop;
  logic [rht_pkg::IDX_W-1:0] rdist;

  assign lim_eff = (lim_q > rht_pkg::LIMIT_MAX) ? rht_pkg::LIMIT_MAX : lim_q;
  assign pct     = (rht_pkg::PCT_W'(100) * (rht_pkg::PCT_W'(count_q) + rht_pkg::PCT_W'(1)))
                   >> rht_pkg::IDX_W;
  assign refuse  = pct > rht_pkg::PCT_W'(lim_eff);

  assign slot_v = valid_q[pos_q];
  assign match  = slot_v && (rd_q.hash == c_q.hash) && (rd_q.len == c_q.len) &&
                  (((rd_q.key ^ c_q.key) & rht_pkg::key_mask(c_q.len)) == 64'd0);
  assign rdist  = pos_q - rd_q.hash[rht_pkg::IDX_W-1:0];
  assign stop   = !slot_v || match || (d_q > rdist) ||
                  (d_q == rht_pkg::IDX_W'(rht_pkg::TABLE_SIZE - 1));

  assign out_load   = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    pos_d   = pos_q;
    d_d     = d_q;
    iter_d  = iter_q;
    req_d   = req_q;
    first_d = first_q;
    count_d = count_q;
    valid_d = valid_q;
    res_d   = res_q;
    we      = 1'b0;
    re      = 1'b0;
    wdata   = c_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c_d.hash  = in_word_i.key_hash;
          c_d.len   = in_word_i.key_length;
          c_d.key   = in_word_i.key_bytes;
          c_d.value = rht_pkg::VALUE_WIDTH'(in_word_i.value);
          req_d     = in_word_i.req_type;
          first_d   = 1'b1;
          iter_d    = '0;
          d_d       = '0;
          pos_d     = in_word_i.key_hash[rht_pkg::IDX_W-1:0];
          if (in_word_i.req_type == rht_pkg::REQ_SET && refuse) begin
            res_d   = '{found: 1'b0, read_value: 32'd0, status: rht_pkg::STATUS_REFUSED};
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!stop) begin
          d_d     = d_q + rht_pkg::IDX_W'(1);
          pos_d   = pos_q + rht_pkg::IDX_W'(1);
          state_d = S_RD;
        end else if (req_q == rht_pkg::REQ_GET) begin
          res_d   = '{found: match, read_value: match ? 32'(rd_q.value) : 32'd0,
                      status: rht_pkg::STATUS_OK};
          state_d = S_DONE;
        end else if (match && first_q) begin
          we          = 1'b1;
          wdata       = rd_q;
          wdata.value = c_q.value;
          res_d       = '{found: 1'b1, read_value: 32'd0, status: rht_pkg::STATUS_OK};
          state_d     = S_DONE;
        end else if (!slot_v) begin
          we             = 1'b1;
          valid_d[pos_q] = 1'b1;
          count_d        = count_q + rht_pkg::CNT_W'(1);
          res_d          = '{found: 1'b0, read_value: 32'd0, status: rht_pkg::STATUS_OK};
          state_d        = S_DONE;
        end else begin
          // swap with richer resident, carry it on
          we      = 1'b1;
          c_d     = rd_q;
          first_d = 1'b0;
          if (iter_q == rht_pkg::CNT_W'(rht_pkg::TABLE_SIZE)) begin
            res_d   = '{found: 1'b0, read_value: 32'd0, status: rht_pkg::STATUS_OK};
            state_d = S_DONE;
          end else begin
            iter_d  = iter_q + rht_pkg::CNT_W'(1);
            d_d     = '0;
            pos_d   = rd_q.hash[rht_pkg::IDX_W-1:0];
            state_d = S_RD;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_q] <= wdata;
    end
    if (re) begin
      rd_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      count_q   <= '0;
      lim_q     <= rht_pkg::LIMIT_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    pos_q   <= pos_d;
    d_q     <= d_d;
    iter_q  <= iter_d;
    req_q   <= req_d;
    first_q <= first_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

>>> rtl/rht_checker.sv
// Port-level checker for the Robin Hood hash table, bound to the top level.
`include "robin_hood_hash_table_assert.svh"

module rht_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rht_pkg::out_word_t out_word_o
);

  `RHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy")
  `RHT_ASSERT(a_refused_not_found, out_valid_o && out_word_o.status |-> !out_word_o.found, "found")
  `RHT_ASSERT(a_refused_no_value, out_valid_o && out_word_o.status |-> !(|out_word_o.read_value), "value")
  `RHT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `RHT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word_o), "result changed")

endmodule

bind robin_hood_hash_table rht_checker u_rht_checker (.*);

>>> dv/tb.sv
// Testbench for the Robin Hood hash table: randomized requests checked against a predictor.
`timescale 1ns / 1ps

module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  rht_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rht_pkg::out_word_t out_word_o;
  logic               cfg_we_i = 1'b0;
  logic [6:0]         cfg_data_i = 7'd0;

  robin_hood_hash_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: shadow copy of the table and the load limit.
  logic        tbl_valid [rht_pkg::TABLE_SIZE];
  logic [31:0] tbl_hash  [rht_pkg::TABLE_SIZE];
  logic [3:0]  tbl_len   [rht_pkg::TABLE_SIZE];
  logic [63:0] tbl_key   [rht_pkg::TABLE_SIZE];
  logic [31:0] tbl_value [rht_pkg::TABLE_SIZE];
  int unsigned tbl_count;
  logic [6:0]  limit_pct;

  rht_pkg::in_word_t  pending_words[$];   // words waiting for the driver
  rht_pkg::out_word_t expected_words[$];  // predicted results, oldest first
  int        mismatches;
  int        got_words, hits, refusals, sets_sent;

  // Key match: hash, full 4-bit length and the compared bytes.
  function automatic bit slot_matches(int s, logic [31:0] h, logic [3:0] l, logic [63:0] k);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++)
      if (b < rht_pkg::KEY_BYTES && b < l) m[b*8 +: 8] = 8'hFF;
    return tbl_hash[s] == h && tbl_len[s] == l && ((tbl_key[s] ^ k) & m) == 0;
  endfunction

  // Linear probe with the Robin Hood early stop; pos is the hit or stop slot.
  function automatic bit find_slot(logic [31:0] h, logic [3:0] l, logic [63:0] k,
                                   output int pos);
    int home, s, rdist;
    home = h % rht_pkg::TABLE_SIZE;
    pos = home;
    for (int d = 0; d < rht_pkg::TABLE_SIZE; d++) begin
      s = (home + d) % rht_pkg::TABLE_SIZE;
      pos = s;
      if (!tbl_valid[s]) return 1'b0;
      if (slot_matches(s, h, l, k)) return 1'b1;
      rdist = (s + rht_pkg::TABLE_SIZE - (tbl_hash[s] % rht_pkg::TABLE_SIZE))
              % rht_pkg::TABLE_SIZE;
      if (d > rdist) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic rht_pkg::out_word_t lookup_or_store(rht_pkg::in_word_t w);
    rht_pkg::out_word_t r;
    int pos, lim, pct;
    logic [31:0] h, th, v, tv;
    logic [3:0]  l, tl;
    logic [63:0] k, tk;
    bit first_pass, hit;
    r = '0;
    r.status = rht_pkg::STATUS_OK;
    if (w.req_type == rht_pkg::REQ_GET) begin
      if (find_slot(w.key_hash, w.key_length, w.key_bytes, pos)) begin
        r.found = 1'b1;
        r.read_value = tbl_value[pos];
      end
      return r;
    end
    lim = (limit_pct > rht_pkg::LIMIT_MAX) ? rht_pkg::LIMIT_MAX : limit_pct;
    pct = (100 * (tbl_count + 1)) / rht_pkg::TABLE_SIZE;
    if (pct > lim) begin
      r.status = rht_pkg::STATUS_REFUSED;
      return r;
    end
    h = w.key_hash; l = w.key_length; k = w.key_bytes; v = w.value;
    first_pass = 1'b1;
    for (int it = 0; it <= rht_pkg::TABLE_SIZE; it++) begin
      hit = find_slot(h, l, k, pos);
      if (hit && first_pass) begin
        tbl_value[pos] = v;
        r.found = 1'b1;
        return r;
      end
      first_pass = 1'b0;
      if (!tbl_valid[pos]) begin
        tbl_valid[pos] = 1'b1;
        tbl_hash[pos] = h; tbl_len[pos] = l; tbl_key[pos] = k; tbl_value[pos] = v;
        tbl_count++;
        return r;
      end
      // swap with the resident and carry it on
      th = tbl_hash[pos]; tl = tbl_len[pos]; tk = tbl_key[pos]; tv = tbl_value[pos];
      tbl_hash[pos] = h; tbl_len[pos] = l; tbl_key[pos] = k; tbl_value[pos] = v;
      h = th; l = tl; k = tk; v = tv;
    end
    return r;
  endfunction

  // Driver: pulls words from the queue, random gap before each.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(lookup_or_store(in_word_i));
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
        in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks results, stalls the output for a drawn number of cycles.
  int          stall_left = 0;
  int unsigned wait_n;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_words++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, out_word_o);
          mismatches++;
        end else begin
          rht_pkg::out_word_t e;
          e = expected_words.pop_front();
          if (e.found !== out_word_o.found || e.read_value !== out_word_o.read_value ||
              e.status !== out_word_o.status) begin
            $display("%0t: expected found=%0b value=%h status=%0b, got found=%0b value=%h status=%0b",
                     $realtime, e.found, e.read_value, e.status,
                     out_word_o.found, out_word_o.read_value, out_word_o.status);
            mismatches++;
          end
          if (e.found) hits++;
          if (e.status == rht_pkg::STATUS_REFUSED) refusals++;
        end
        wait_n = $urandom_range(0, 16);
        stall_left <= int'(wait_n);
        out_stall_i <= (wait_n != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // Known keys so gets and replacing sets hit.
  rht_pkg::in_word_t known_keys[$];

  function automatic rht_pkg::in_word_t rand_word(bit want_known);
    rht_pkg::in_word_t w;
    w.req_type   = 1'($urandom_range(0, 1));
    w.key_hash   = $urandom();
    // cluster homes to build long probe runs
    if ($urandom_range(0, 1)) w.key_hash[5:0] = 6'($urandom_range(0, 7));
    w.key_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    w.key_bytes  = {$urandom(), $urandom()};
    w.value      = $urandom();
    if (want_known && known_keys.size() > 0) begin
      rht_pkg::in_word_t k;
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      w.key_hash = k.key_hash;
      w.key_length = k.key_length;
      // bytes beyond the length must not matter
      w.key_bytes = k.key_bytes ^
                    ({$urandom(), $urandom()} & ~rht_pkg::key_mask(k.key_length));
      // near miss: same hash, length differs
      if ($urandom_range(0, 9) == 0) w.key_length = k.key_length ^ 4'd1;
    end
    if (w.req_type == rht_pkg::REQ_SET) known_keys.push_back(w);
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] pct);
    @(posedge clk_i);
    cfg_data_i <= pct;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_pct = pct;
  endtask

  initial begin
    rht_pkg::in_word_t w;
    logic [6:0] limits[5];
    limits = '{7'd100, 7'd1, 7'd127, 7'd0, 7'd50};
    mismatches = 0; got_words = 0; hits = 0; refusals = 0; sets_sent = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    limit_pct = rht_pkg::LIMIT_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of each field, get miss on empty table, replace, near misses.
    w = '0; w.req_type = rht_pkg::REQ_GET; pending_words.push_back(w);
    w = '0; w.req_type = rht_pkg::REQ_SET; w.value = '1; pending_words.push_back(w);
    w.req_type = rht_pkg::REQ_GET; pending_words.push_back(w);
    w = '1; w.key_length = 4'd8; w.req_type = rht_pkg::REQ_SET; pending_words.push_back(w);
    w.value = 32'h0; pending_words.push_back(w);
    w.req_type = rht_pkg::REQ_GET; pending_words.push_back(w);
    w.key_length = 4'd15; pending_words.push_back(w);
    w.req_type = rht_pkg::REQ_SET; w.value = 32'hA5A5_5A5A; pending_words.push_back(w);
    w.req_type = rht_pkg::REQ_GET; w.key_bytes = 64'h0; pending_words.push_back(w);
    w.key_hash = 32'hFFFF_FFC0; pending_words.push_back(w);
    for (int i = 0; i < 8; i++) begin
      w = '0; w.req_type = rht_pkg::REQ_SET; w.key_hash = {26'(i), 6'd5};
      w.key_length = 4'(i); w.key_bytes = 64'h0123_4567_89AB_CDEF; w.value = 32'(i);
      pending_words.push_back(w);
      known_keys.push_back(w);
    end
    for (int i = 0; i < 8; i++) begin
      w = known_keys[i]; w.req_type = rht_pkg::REQ_GET; pending_words.push_back(w);
    end
    wait_drained();

    // Random phases across several limits; fill toward each limit.
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_limit(limits[p - 1]);
      for (int n = 0; n < 125; n++) begin
        pending_words.push_back(rand_word($urandom_range(0, 1)));
      end
      wait_drained();
    end

    $display("Checked %0d result words: %0d hits, %0d refused sets.", got_words, hits, refusals);
    $display("Table held %0d entries; load limits 0, 1, 50, 80, 100 and 127 exercised.",
             tbl_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
